// ----- sv/hpt_pkg.sv -----
// Shared constants, register codes and stage records of the homogeneous point transform.
// No dependencies; every module of the block imports this package.
package hpt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 32;
    localparam int PT_WIDTH   = 32;
    localparam int PW         = PT_WIDTH + COEF_WIDTH;   // one product
    localparam int DW         = PW + 2;                  // one row dot product
    localparam int MW         = DW;                      // magnitude of a dot product
    localparam int NW         = MW + FRAC_BITS;          // shifted numerator
    localparam int QB         = PT_WIDTH + 1;            // quotient bits formed
    localparam int RW         = MW + 1;                  // partial remainder
    localparam int TOPW       = NW - QB;                 // numerator bits above the quotient
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LAT        = 4 + QB + 1;              // start to done, in cycles

    localparam logic [PT_WIDTH-1:0] ONE_FIXED = PT_WIDTH'(1) << FRAC_BITS;
    localparam logic [PT_WIDTH-1:0] POS_MAX   = {1'b0, {(PT_WIDTH-1){1'b1}}};
    localparam logic [PT_WIDTH-1:0] NEG_MIN   = {1'b1, {(PT_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX    = 3'd0,
        REG_COEF_XY    = 3'd1,
        REG_SHIFT_X    = 3'd2,
        REG_COEF_YX    = 3'd3,
        REG_COEF_YY    = 3'd4,
        REG_SHIFT_Y    = 3'd5,
        REG_PERSP_PAIR = 3'd6,
        REG_PERSP_W    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] m00;
        logic signed [COEF_WIDTH-1:0] m01;
        logic signed [COEF_WIDTH-1:0] m02;
        logic signed [COEF_WIDTH-1:0] m10;
        logic signed [COEF_WIDTH-1:0] m11;
        logic signed [COEF_WIDTH-1:0] m12;
        logic signed [COEF_WIDTH-1:0] m20;
        logic signed [COEF_WIDTH-1:0] m21;
        logic signed [COEF_WIDTH-1:0] m22;
    } matrix_t;

    typedef struct packed {
        logic                 valid;
        logic signed [DW-1:0] tx;
        logic signed [DW-1:0] ty;
        logic signed [DW-1:0] tw;
    } dot_t;

    typedef struct packed {
        logic          valid;
        logic          wz;
        logic          negx;
        logic          negy;
        logic          ovx;
        logic          ovy;
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic [QB-1:0] nx;
        logic [QB-1:0] ny;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
        logic [MW-1:0] d;
    } div_t;

endpackage

// ----- sv/homogeneous_point_transform_unit.sv -----
// Top level of the homogeneous 2D point transform: matrix registers and full pipeline.
// Depends on hpt_pkg, hpt_dot, hpt_prep and hpt_div_stage.
//
// Maps each point (x, y), Q16.16, through the 3x3 matrix in the eight registers, with w = 1,
// and divides x and y by w, rounding toward zero and saturating to Q16.16. A transaction is
// taken at every edge with start high; busy never rises, so one point enters each cycle.
// Every result passes the product and row-sum stages, the magnitude and overflow stages,
// 33 division stages with one quotient bit each, and the sign and saturation register before
// it appears on done. The receiver cannot stall, so there is no back-pressure anywhere in
// the pipeline. w_zero flags a zero w with both outputs zero; saturated flags a clamped
// quotient. Write registers only while no point is in flight.
module homogeneous_point_transform_unit
    import hpt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [PT_WIDTH-1:0]   point_x,
    input  logic signed [PT_WIDTH-1:0]   point_y,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         done,
    output logic signed [PT_WIDTH-1:0]   mapped_x,
    output logic signed [PT_WIDTH-1:0]   mapped_y,
    output logic                         w_zero,
    output logic                         saturated
);

    logic [PT_WIDTH-1:0] coef_xx_reg, coef_xy_reg, shift_x_reg;
    logic [PT_WIDTH-1:0] coef_yx_reg, coef_yy_reg, shift_y_reg;
    logic [PT_WIDTH-1:0] persp_x_reg, persp_y_reg, persp_w_reg;
    matrix_t             mat;
    dot_t                dot;
    div_t                div_pipe [QB+1];
    logic                done_reg, wz_reg, sat_reg;
    logic [PT_WIDTH-1:0] mx_reg, my_reg;
    logic                sx, sy;
    logic [PT_WIDTH-1:0] vx, vy;

    assign busy = 1'b0;

    // matrix registers; persp_pair holds column 0 in its low half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= ONE_FIXED;
            coef_xy_reg <= '0;
            shift_x_reg <= '0;
            coef_yx_reg <= '0;
            coef_yy_reg <= ONE_FIXED;
            shift_y_reg <= '0;
            persp_x_reg <= '0;
            persp_y_reg <= '0;
            persp_w_reg <= ONE_FIXED;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_XX: coef_xx_reg <= cfg_data[PT_WIDTH-1:0];
                REG_COEF_XY: coef_xy_reg <= cfg_data[PT_WIDTH-1:0];
                REG_SHIFT_X: shift_x_reg <= cfg_data[PT_WIDTH-1:0];
                REG_COEF_YX: coef_yx_reg <= cfg_data[PT_WIDTH-1:0];
                REG_COEF_YY: coef_yy_reg <= cfg_data[PT_WIDTH-1:0];
                REG_SHIFT_Y: shift_y_reg <= cfg_data[PT_WIDTH-1:0];
                REG_PERSP_PAIR:
                begin
                    persp_x_reg <= cfg_data[PT_WIDTH-1:0];
                    persp_y_reg <= cfg_data[2*PT_WIDTH-1:PT_WIDTH];
                end
                REG_PERSP_W: persp_w_reg <= cfg_data[PT_WIDTH-1:0];
            endcase
        end
    end

    // take only the low coefficient bits, as signed values
    always_comb
    begin
        mat.m00 = coef_xx_reg[COEF_WIDTH-1:0];
        mat.m01 = coef_xy_reg[COEF_WIDTH-1:0];
        mat.m02 = shift_x_reg[COEF_WIDTH-1:0];
        mat.m10 = coef_yx_reg[COEF_WIDTH-1:0];
        mat.m11 = coef_yy_reg[COEF_WIDTH-1:0];
        mat.m12 = shift_y_reg[COEF_WIDTH-1:0];
        mat.m20 = persp_x_reg[COEF_WIDTH-1:0];
        mat.m21 = persp_y_reg[COEF_WIDTH-1:0];
        mat.m22 = persp_w_reg[COEF_WIDTH-1:0];
    end

    hpt_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .px       (point_x),
        .py       (point_y),
        .mat      (mat),
        .dot_reg  (dot)
    );

    hpt_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .dot     (dot),
        .div_reg (div_pipe[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        hpt_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .din      (div_pipe[g]),
            .dout_reg (div_pipe[g+1])
        );
    end

    function automatic logic [PT_WIDTH:0] finish(input logic neg, input logic ov,
                                                 input logic [QB-1:0] q);
        logic [QB-1:0]       limit;
        logic                sat;
        logic [PT_WIDTH-1:0] val;
        limit = neg ? QB'(NEG_MIN) : QB'(POS_MAX);
        sat   = ov || (q > limit);
        if (sat)
            val = neg ? NEG_MIN : POS_MAX;
        else
            val = neg ? (~q[PT_WIDTH-1:0] + PT_WIDTH'(1)) : q[PT_WIDTH-1:0];
        return {sat, val};
    endfunction

    always_comb
    begin
        {sx, vx} = finish(div_pipe[QB].negx, div_pipe[QB].ovx, div_pipe[QB].qx);
        {sy, vy} = finish(div_pipe[QB].negy, div_pipe[QB].ovy, div_pipe[QB].qy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_pipe[QB].valid;
    end

    // zero w: drop the quotients and the clamp flag
    always_ff @(posedge clk)
    begin
        wz_reg  <= div_pipe[QB].wz;
        sat_reg <= (sx | sy) & ~div_pipe[QB].wz;
        mx_reg  <= div_pipe[QB].wz ? '0 : vx;
        my_reg  <= div_pipe[QB].wz ? '0 : vy;
    end

    assign done      = done_reg;
    assign mapped_x  = mx_reg;
    assign mapped_y  = my_reg;
    assign w_zero    = wz_reg;
    assign saturated = sat_reg;

    a_wz_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(w_zero && saturated))
        else $error("w_zero and saturated both set");

    a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && w_zero) |-> (mapped_x == '0 && mapped_y == '0))
        else $error("zero w with nonzero outputs");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (mapped_x == POS_MAX || mapped_x == NEG_MIN ||
                                 mapped_y == POS_MAX || mapped_y == NEG_MIN))
        else $error("saturated without a clamped output");

endmodule

// ----- sv/hpt_dot.sv -----
// Two pipeline stages: the six coordinate products, then the three row sums.
// Depends on hpt_pkg.
module hpt_dot
    import hpt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [PT_WIDTH-1:0] px,
    input  logic signed [PT_WIDTH-1:0] py,
    input  matrix_t                    mat,
    output dot_t                       dot_reg
);

    logic                 valid_reg;
    logic signed [PW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    dot_t                 dot_next;

    // only the valid bits are reset; the data simply follows them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            dot_reg.valid <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            p00_reg   <= PW'(mat.m00) * PW'(px);
            p01_reg   <= PW'(mat.m01) * PW'(py);
            p10_reg   <= PW'(mat.m10) * PW'(px);
            p11_reg   <= PW'(mat.m11) * PW'(py);
            p20_reg   <= PW'(mat.m20) * PW'(px);
            p21_reg   <= PW'(mat.m21) * PW'(py);
            dot_reg   <= dot_next;
        end
    end

    // third column is scaled by 1.0
    always_comb
    begin
        dot_next       = '0;
        dot_next.valid = valid_reg;
        dot_next.tx = DW'(p00_reg) + DW'(p01_reg) + (DW'(mat.m02) <<< FRAC_BITS);
        dot_next.ty = DW'(p10_reg) + DW'(p11_reg) + (DW'(mat.m12) <<< FRAC_BITS);
        dot_next.tw = DW'(p20_reg) + DW'(p21_reg) + (DW'(mat.m22) <<< FRAC_BITS);
    end

endmodule

// ----- sv/hpt_prep.sv -----
// Two pipeline stages: magnitudes and signs, then overflow test and divider set-up.
// Depends on hpt_pkg.
module hpt_prep
    import hpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  dot_t dot,
    output div_t div_reg
);

    logic          valid_reg, wz_reg, negx_reg, negy_reg;
    logic [MW-1:0] ax_reg, ay_reg, aw_reg;
    logic [DW-1:0] ux, uy, uw;
    logic [NW-1:0] nfx, nfy;
    logic [MW-1:0] topx, topy;
    div_t          div_next;

    assign ux = dot.tx;
    assign uy = dot.ty;
    assign uw = dot.tw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            div_reg.valid <= 1'b0;
        end
        else
        begin
            valid_reg <= dot.valid;
            ax_reg    <= ux[DW-1] ? MW'(~ux + DW'(1)) : MW'(ux);
            ay_reg    <= uy[DW-1] ? MW'(~uy + DW'(1)) : MW'(uy);
            aw_reg    <= uw[DW-1] ? MW'(~uw + DW'(1)) : MW'(uw);
            negx_reg  <= ux[DW-1] ^ uw[DW-1];
            negy_reg  <= uy[DW-1] ^ uw[DW-1];
            wz_reg    <= (uw == '0);
            div_reg   <= div_next;
        end
    end

    // a quotient of more than QB bits is an overflow; hold the remainder at zero then
    always_comb
    begin
        nfx  = NW'(ax_reg) << FRAC_BITS;
        nfy  = NW'(ay_reg) << FRAC_BITS;
        topx = MW'(nfx[NW-1:QB]);
        topy = MW'(nfy[NW-1:QB]);
        div_next       = '0;
        div_next.valid = valid_reg;
        div_next.wz    = wz_reg;
        div_next.negx  = negx_reg;
        div_next.negy  = negy_reg;
        div_next.ovx   = (topx >= aw_reg);
        div_next.ovy   = (topy >= aw_reg);
        div_next.rx    = div_next.ovx ? '0 : RW'(topx);
        div_next.ry    = div_next.ovy ? '0 : RW'(topy);
        div_next.nx    = nfx[QB-1:0];
        div_next.ny    = nfy[QB-1:0];
        div_next.d     = aw_reg;
    end

endmodule

// ----- sv/hpt_div_stage.sv -----
// One registered restoring-division step for both quotients, sharing the divisor.
// Depends on hpt_pkg.
module hpt_div_stage
    import hpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_t din,
    output div_t dout_reg
);

    logic [RW-1:0] shx, shy, dd;
    logic          gex, gey;
    div_t          dout_next;

    always_comb
    begin
        dd  = {1'b0, din.d};
        shx = {din.rx[RW-2:0], din.nx[QB-1]};
        shy = {din.ry[RW-2:0], din.ny[QB-1]};
        gex = (shx >= dd);
        gey = (shy >= dd);
        dout_next    = din;
        dout_next.rx = gex ? shx - dd : shx;
        dout_next.ry = gey ? shy - dd : shy;
        dout_next.qx = {din.qx[QB-2:0], gex};
        dout_next.qy = {din.qy[QB-2:0], gey};
        dout_next.nx = {din.nx[QB-2:0], 1'b0};
        dout_next.ny = {din.ny[QB-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg.valid <= 1'b0;
        else
            dout_reg <= dout_next;
    end

endmodule

// ----- sim/homogeneous_point_transform_unit_tb.sv -----
// Self-checking testbench of the homogeneous point transform unit.
// Depends on hpt_pkg and homogeneous_point_transform_unit; runs directed rows, then random points.
module homogeneous_point_transform_unit_tb;
    import hpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 1500;
    localparam int N_DIRECTED     = 16;

    typedef struct {
        logic [31:0] mx;
        logic [31:0] my;
        logic        wz;
        logic        sat;
    } mapped_t;

    // One directed row: the point, and whether the expected value is typed in.
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic        typed;
        mapped_t     res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [31:0]    point_x;
    logic signed [31:0]    point_y;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic signed [31:0]    mapped_x;
    logic signed [31:0]    mapped_y;
    logic                  w_zero;
    logic                  saturated;

    logic [63:0] matrix_regs [0:7];
    mapped_t     pending_points [$];
    int          error_count;
    int          idle_cycles;
    int          results_seen;
    int          wz_seen;
    int          sat_seen;
    stim_row_t   directed_rows [N_DIRECTED];

    homogeneous_point_transform_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .mapped_x  (mapped_x),
        .mapped_y  (mapped_y),
        .w_zero    (w_zero),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Divide (num << FRAC_BITS) by den, truncate toward zero, clamp to 32 bits.
    function automatic logic [31:0] divide_clamp(logic signed [127:0] num,
                                                 logic signed [127:0] den,
                                                 ref logic sat);
        logic              neg;
        logic [127:0]      mag_n;
        logic [127:0]      mag_d;
        logic [127:0]      q;
        neg   = num[127] ^ den[127];
        mag_n = num[127] ? -num : num;
        mag_d = den[127] ? -den : den;
        q     = (mag_n << FRAC_BITS) / mag_d;
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 128'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic mapped_t map_point(logic [31:0] px, logic [31:0] py);
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] m [0:8];
        logic signed [127:0] tx;
        logic signed [127:0] ty;
        logic signed [127:0] tw;
        mapped_t             r;
        logic                sat;
        x = 128'(signed'(px));
        y = 128'(signed'(py));
        for (int i = 0; i < 6; i++)
            m[i] = 128'(signed'(matrix_regs[i][31:0]));
        m[6] = 128'(signed'(matrix_regs[REG_PERSP_PAIR][31:0]));
        m[7] = 128'(signed'(matrix_regs[REG_PERSP_PAIR][63:32]));
        m[8] = 128'(signed'(matrix_regs[REG_PERSP_W][31:0]));
        tx = m[0] * x + m[1] * y + (m[2] <<< FRAC_BITS);
        ty = m[3] * x + m[4] * y + (m[5] <<< FRAC_BITS);
        tw = m[6] * x + m[7] * y + (m[8] <<< FRAC_BITS);
        sat = 1'b0;
        if (tw == 0)
        begin
            r = '{32'd0, 32'd0, 1'b1, 1'b0};
            return r;
        end
        r.mx  = divide_clamp(tx, tw, sat);
        r.my  = divide_clamp(ty, tw, sat);
        r.wz  = 1'b0;
        r.sat = sat;
        return r;
    endfunction

    // Write one register at the next edge; only while the pipeline is empty.
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        matrix_regs[idx] = (idx == REG_PERSP_PAIR) ? value : {32'd0, value[31:0]};
    endtask

    // Drive one point at a falling edge; the transaction completes at the next rising edge.
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic typed, mapped_t res);
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_points.push_back(typed ? res : map_point(px, py));
        @(negedge clk);
    endtask

    // Hold off between bursts; a zero-length gap keeps start high.
    task automatic idle_gap(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Drain: wait until every expected result arrived, then let the pipeline settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (LAT + 2) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_matrix(int style);
        logic [31:0] lo;
        logic [31:0] hi;
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(i), (style == 0) ? {32'd0, $urandom} :
                                     {32'd0, 32'($signed($urandom_range(0, 8192)) - 4096) <<< 4});
        lo = (style == 0) ? $urandom : 32'($signed($urandom_range(0, 64)) - 32);
        hi = (style == 0) ? $urandom : 32'($signed($urandom_range(0, 64)) - 32);
        write_reg(REG_PERSP_PAIR, {hi, lo});
        write_reg(REG_PERSP_W, (style == 0) ? {32'd0, $urandom} :
                               {32'd0, 32'($urandom_range(1, 4)) << 16});
    endtask

    // Check every result against the oldest expectation; the receiver never stalls.
    always @(posedge clk)
    begin
        mapped_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (w_zero)
                wz_seen++;
            if (saturated)
                sat_seen++;
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h", $time, mapped_x, mapped_y);
                error_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (mapped_x !== want.mx)
                begin
                    $display("%0t: mapped_x expected %h actual %h", $time, want.mx, mapped_x);
                    error_count++;
                end
                if (mapped_y !== want.my)
                begin
                    $display("%0t: mapped_y expected %h actual %h", $time, want.my, mapped_y);
                    error_count++;
                end
                if (w_zero !== want.wz)
                begin
                    $display("%0t: w_zero expected %b actual %b", $time, want.wz, w_zero);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        mapped_t none;
        none = '{32'd0, 32'd0, 1'b0, 1'b0};
        // Identity after reset: a point maps onto itself. Extremes and zero w follow.
        directed_rows[0]  = '{32'h0001_0000, 32'h0002_0000, 1'b1,
                              '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0}};
        directed_rows[1]  = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                              '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0}};
        directed_rows[2]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                              '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0}};
        directed_rows[3]  = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, none};
        for (int i = 4; i < N_DIRECTED; i++)
            directed_rows[i] = '{$urandom, $urandom, 1'b0, none};

        rst_n = 1'b0; start = 1'b0; point_x = '0; point_y = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        error_count = 0; idle_cycles = 0; results_seen = 0; wz_seen = 0; sat_seen = 0;
        matrix_regs[0] = 64'h1_0000; matrix_regs[1] = 0; matrix_regs[2] = 0;
        matrix_regs[3] = 0; matrix_regs[4] = 64'h1_0000; matrix_regs[5] = 0;
        matrix_regs[6] = 0; matrix_regs[7] = 64'h1_0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_point(directed_rows[i].px, directed_rows[i].py,
                       directed_rows[i].typed, directed_rows[i].res);
        drain();

        // Zero w: w = 0 at the origin gives zero outputs and the flag.
        write_reg(REG_PERSP_W, 64'd0);
        send_point(32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0});
        send_point(32'h0001_0000, 32'h0001_0000, 1'b0, none);
        drain();
        // Tiny w with a large translation drives both quotients into saturation.
        write_reg(REG_PERSP_W, 64'd1);
        write_reg(REG_SHIFT_X, 64'h7FFF_FFFF);
        write_reg(REG_SHIFT_Y, 64'h8000_0000);
        send_point(32'd0, 32'd0, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1});
        drain();
        // Extreme coefficients everywhere, both halves of the perspective pair at the limits.
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(i), {32'd0, (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF});
        write_reg(REG_PERSP_PAIR, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_PERSP_W, 64'hFFFF_FFFF_8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, none);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0, none);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, none);
        drain();

        // Random phases: alternate wild and tame matrices; bursts with random gaps.
        for (int phase = 0; phase < 10; phase++)
        begin
            random_matrix(phase % 2);
            for (int n = 0; n < N_RANDOM / 10; )
            begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && n < N_RANDOM / 10; k++, n++)
                    send_point(rand_coord(), rand_coord(), 1'b0, none);
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
            drain();
        end

        $display("Checked %0d results over directed rows and 10 random matrices;", results_seen);
        $display("%0d had zero w and %0d saturated.", wz_seen, sat_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
